// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LAGS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LAGS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lags_pkg.sv =====
`timescale 1ns / 1ps

package lags_pkg;

    // Default sizing of the top level
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_SCORE_BITS = 24;

    // Fixed field widths
    localparam int LEN_W       = 11;
    localparam int GAP_W       = 12;
    localparam int CELL_W      = 16;
    localparam int OUT_SCORE_W = 23;
    localparam int OUT_POS_W   = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_ROW_LENGTH = 11'd1024;
    localparam logic [GAP_W-1:0] RST_GAP_OPEN   = 12'd160;
    localparam logic [GAP_W-1:0] RST_GAP_EXTEND = 12'd16;

    // Largest reportable score
    localparam logic [OUT_SCORE_W-1:0] OUT_SCORE_MAX = '1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 2'd0,
        REG_GAP_OPEN   = 2'd1,
        REG_GAP_EXTEND = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0] row_length;
        logic [GAP_W-1:0] gap_open;
        logic [GAP_W-1:0] gap_extend;
    } t_cfg;

    // Control for the cell stage
    typedef struct packed {
        logic fire;
        logic last;
        logic first_row;
        logic first_col;
    } t_cell_ctl;

endpackage

// ===== src/lags_cfg.sv =====
`timescale 1ns / 1ps

module lags_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lags_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lags_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lags_pkg::t_cfg                      o_cfg
);

    lags_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_length <= lags_pkg::RST_ROW_LENGTH;
            r_cfg.gap_open   <= lags_pkg::RST_GAP_OPEN;
            r_cfg.gap_extend <= lags_pkg::RST_GAP_EXTEND;
        end else if (i_cfg_valid) begin
            unique case (lags_pkg::t_cfg_reg'(i_cfg_index))
                lags_pkg::REG_ROW_LENGTH: begin
                    r_cfg.row_length <= i_cfg_data[lags_pkg::LEN_W-1:0];
                end
                lags_pkg::REG_GAP_OPEN: begin
                    r_cfg.gap_open <= i_cfg_data[lags_pkg::GAP_W-1:0];
                end
                lags_pkg::REG_GAP_EXTEND: begin
                    r_cfg.gap_extend <= i_cfg_data[lags_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/lags_seq.sv =====
`timescale 1ns / 1ps

module lags_seq #(
    parameter int MAX_COLS = lags_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lags_pkg::DEF_MAX_ROWS,
    parameter int COL_W    = 11,
    parameter int ROW_W    = 11,
    parameter int ADDR_W   = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lags_pkg::CELL_W-1:0]  i_cell_score,
    input  logic                                i_last_cell,
    input  logic [lags_pkg::LEN_W-1:0]          i_row_length,
    input  logic                                i_out_stall,
    output logic                                o_rd_en,
    output logic [ADDR_W-1:0]                   o_rd_addr,
    output lags_pkg::t_cell_ctl                 o_ctl,
    output logic [ADDR_W-1:0]                   o_addr,
    output logic [ROW_W-1:0]                    o_row,
    output logic [COL_W-1:0]                    o_col,
    output logic signed [lags_pkg::CELL_W-1:0]  o_score
);

    logic                               accept;
    logic                               s1_fire;
    logic [COL_W-1:0]                   len_eff;
    logic                               wrap;
    logic [COL_W-1:0]                   cur_col;
    logic [ROW_W-1:0]                   wrap_row;
    logic [ROW_W-1:0]                   cur_row;
    logic [ROW_W-1:0]                   inc_row;
    logic [ADDR_W-1:0]                  cur_addr;

    logic [COL_W-1:0]                   r_col, n_col;
    logic [ROW_W-1:0]                   r_row, n_row;

    logic                               r_s1_valid;
    logic                               r_last;
    logic                               r_first_row;
    logic                               r_first_col;
    logic [ADDR_W-1:0]                  r_addr;
    logic [ROW_W-1:0]                   r_s1_row;
    logic [COL_W-1:0]                   r_s1_col;
    logic signed [lags_pkg::CELL_W-1:0] r_score;

    // Stage 1 waits only on a final cell while a result sits untaken
    assign s1_fire    = r_s1_valid && !(r_last && i_out_stall);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign accept     = i_in_valid && o_in_ready;

    // Row length clamped to 1..MAX_COLS
    always_comb begin
        if (i_row_length == '0) begin
            len_eff = COL_W'(1);
        end else if (32'(i_row_length) > MAX_COLS) begin
            len_eff = COL_W'(MAX_COLS);
        end else begin
            len_eff = COL_W'(i_row_length);
        end
    end

    // Position of the arriving cell; a shortened row opens a new one
    always_comb begin
        wrap     = r_col > len_eff;
        wrap_row = (r_row < ROW_W'(MAX_ROWS)) ? r_row + 1'b1 : r_row;
        cur_col  = wrap ? COL_W'(1) : r_col;
        cur_row  = wrap ? wrap_row : r_row;
        inc_row  = (cur_row < ROW_W'(MAX_ROWS)) ? cur_row + 1'b1 : cur_row;
        cur_addr = ADDR_W'(cur_col - COL_W'(1));
    end

    // Next counter values after this cell
    always_comb begin
        if (i_last_cell) begin
            n_col = COL_W'(1);
            n_row = ROW_W'(1);
        end else if (cur_col >= len_eff) begin
            n_col = COL_W'(1);
            n_row = inc_row;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    // Cell counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= COL_W'(1);
            r_row <= ROW_W'(1);
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last      <= i_last_cell;
            r_first_row <= cur_row <= ROW_W'(1);
            r_first_col <= cur_col == COL_W'(1);
            r_addr      <= cur_addr;
            r_s1_row    <= cur_row;
            r_s1_col    <= cur_col;
            r_score     <= i_cell_score;
        end
    end

    assign o_rd_en         = accept;
    assign o_rd_addr       = cur_addr;
    assign o_ctl.fire      = s1_fire;
    assign o_ctl.last      = r_last;
    assign o_ctl.first_row = r_first_row;
    assign o_ctl.first_col = r_first_col;
    assign o_addr          = r_addr;
    assign o_row           = r_s1_row;
    assign o_col           = r_s1_col;
    assign o_score         = r_score;

endmodule

// ===== src/lags_rowbuf.sv =====
`timescale 1ns / 1ps

module lags_rowbuf #(
    parameter int                DEPTH     = lags_pkg::DEF_MAX_COLS,
    parameter int                ADDR_W    = 10,
    parameter int                DATA_W    = 48,
    parameter logic [DATA_W-1:0] INIT_DATA = '0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]   i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [DATA_W-1:0]   o_rd_data
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [FILL_W-1:0] r_fill;
    logic              unwritten;

    // Writes only ever grow a prefix from address 0, so one mark covers every entry
    assign unwritten = FILL_W'(i_rd_addr) >= r_fill;

    // Fill mark: count of entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (FILL_W'(i_wr_addr) == r_fill)) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // One write and one registered read a cycle; a same-address write is passed through
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (unwritten) begin
                r_rd_data <= INIT_DATA;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lags_cell.sv =====
`timescale 1ns / 1ps

module lags_cell #(
    parameter int SCORE_BITS = lags_pkg::DEF_SCORE_BITS,
    parameter int COL_W      = 11,
    parameter int ROW_W      = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lags_pkg::t_cell_ctl                 i_ctl,
    input  logic [ROW_W-1:0]                    i_row,
    input  logic [COL_W-1:0]                    i_col,
    input  logic signed [lags_pkg::CELL_W-1:0]  i_score,
    input  logic [2*SCORE_BITS-1:0]             i_rd_data,
    input  lags_pkg::t_cfg                      i_cfg,
    output logic                                o_wr_en,
    output logic [2*SCORE_BITS-1:0]             o_wr_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lags_pkg::OUT_SCORE_W-1:0]    o_best_score,
    output logic [lags_pkg::OUT_POS_W-1:0]      o_end_row,
    output logic [lags_pkg::OUT_POS_W-1:0]      o_end_col
);

    localparam int WB = SCORE_BITS + 2;
    localparam logic signed [WB-1:0] SAT_HI = {3'b000, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [WB-1:0] SAT_LO = {3'b111, {(SCORE_BITS-1){1'b0}}};

    function automatic logic signed [SCORE_BITS-1:0] sat(input logic signed [WB-1:0] x);
        logic signed [SCORE_BITS-1:0] res;
        if (x > SAT_HI) begin
            res = SAT_HI[SCORE_BITS-1:0];
        end else if (x < SAT_LO) begin
            res = SAT_LO[SCORE_BITS-1:0];
        end else begin
            res = x[SCORE_BITS-1:0];
        end
        return res;
    endfunction

    logic signed [WB-1:0]           g_w, h_w, m_w, neg_g_w;
    logic signed [SCORE_BITS-1:0]   neg_g;
    logic signed [SCORE_BITS-1:0]   rd_best, rd_vgap;
    logic signed [SCORE_BITS-1:0]   up_c, up_d, diag, left, hgap;
    logic signed [SCORE_BITS-1:0]   ev_o, ev_e, ev, dv_o, dv_e, dv;
    logic signed [SCORE_BITS-1:0]   cv0, cv1, cv;
    logic signed [SCORE_BITS-1:0]   cv_f, dv_f, ev_f;
    logic                           upd;
    logic signed [SCORE_BITS-1:0]   bs_sel;
    logic [ROW_W-1:0]               row_sel;
    logic [COL_W-1:0]               col_sel;
    logic signed [63:0]             bs64;
    logic [lags_pkg::OUT_SCORE_W-1:0] bs_out;

    logic signed [SCORE_BITS-1:0]   r_diag, r_left, r_hgap;
    logic signed [SCORE_BITS-1:0]   r_max;
    logic [ROW_W-1:0]               r_max_row;
    logic [COL_W-1:0]               r_max_col;
    logic                           r_out_valid;
    logic [lags_pkg::OUT_SCORE_W-1:0] r_best_score;
    logic [lags_pkg::OUT_POS_W-1:0] r_end_row, r_end_col;

    // Penalties widened to the working width
    always_comb begin
        g_w     = $signed(WB'(i_cfg.gap_open));
        h_w     = $signed(WB'(i_cfg.gap_extend));
        m_w     = g_w + h_w;
        neg_g_w = -g_w;
        neg_g   = neg_g_w[SCORE_BITS-1:0];
        rd_best = i_rd_data[2*SCORE_BITS-1:SCORE_BITS];
        rd_vgap = i_rd_data[SCORE_BITS-1:0];
    end

    // Neighbour values, forced at the matrix edges
    always_comb begin
        up_c = i_ctl.first_row ? '0 : rd_best;
        up_d = i_ctl.first_row ? neg_g : rd_vgap;
        diag = i_ctl.first_col ? '0 : r_diag;
        left = i_ctl.first_col ? '0 : r_left;
        hgap = i_ctl.first_col ? neg_g : r_hgap;
    end

    // Gotoh recurrence with saturating arithmetic
    always_comb begin
        ev_o = sat(WB'(left) - m_w);
        ev_e = sat(WB'(hgap) - h_w);
        ev   = (ev_o > ev_e) ? ev_o : ev_e;
        dv_o = sat(WB'(up_c) - m_w);
        dv_e = sat(WB'(up_d) - h_w);
        dv   = (dv_o > dv_e) ? dv_o : dv_e;
        cv0  = sat(WB'(diag) + WB'(i_score));
        cv1  = (ev > cv0) ? ev : cv0;
        cv   = (dv > cv1) ? dv : cv1;
        // local alignment: negative cell restarts at zero
        cv_f = cv[SCORE_BITS-1] ? '0 : cv;
        dv_f = cv[SCORE_BITS-1] ? neg_g : dv;
        ev_f = cv[SCORE_BITS-1] ? neg_g : ev;
    end

    // Running maximum including this cell, and clamped result score
    always_comb begin
        upd     = cv_f > r_max;
        bs_sel  = upd ? cv_f : r_max;
        row_sel = upd ? i_row : r_max_row;
        col_sel = upd ? i_col : r_max_col;
        bs64    = 64'(bs_sel);
        if (bs_sel[SCORE_BITS-1]) begin
            bs_out = '0;
        end else if (bs64 > $signed(64'(lags_pkg::OUT_SCORE_MAX))) begin
            bs_out = lags_pkg::OUT_SCORE_MAX;
        end else begin
            bs_out = lags_pkg::OUT_SCORE_W'(bs64);
        end
    end

    assign o_wr_en   = i_ctl.fire;
    assign o_wr_data = {cv_f, dv_f};

    // Within-row carried values
    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_diag <= up_c;
            r_left <= cv_f;
            r_hgap <= ev_f;
        end
    end

    // Best cell tracking, restarted after the final cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= '1;
            r_max_row <= '0;
            r_max_col <= '0;
        end else if (i_ctl.fire) begin
            if (i_ctl.last) begin
                r_max     <= '1;
                r_max_row <= '0;
                r_max_col <= '0;
            end else if (upd) begin
                r_max     <= cv_f;
                r_max_row <= i_row;
                r_max_col <= i_col;
            end
        end
    end

    // Result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.fire && i_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && i_ctl.last) begin
            r_best_score <= bs_out;
            r_end_row    <= lags_pkg::OUT_POS_W'(row_sel);
            r_end_col    <= lags_pkg::OUT_POS_W'(col_sel);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_score = r_best_score;
    assign o_end_row    = r_end_row;
    assign o_end_col    = r_end_col;

endmodule

// ===== src/local_affine_gap_alignment_scorer_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake                  | Beat contents
// in      | i_in_valid / o_in_ready    | i_cell_score, i_last_cell
// out     | o_out_valid / i_out_ready  | o_best_score, o_end_row, o_end_col
// cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One cell a cycle, save for the input stall below. A taken final cell loads the input
// register and registered row buffer read; the cell datapath then sets the result.
// Reset (i_rst_n low, synchronous) restores registers and counters; the row
// buffer keeps a fill mark, so entries unwritten since reset read best 0 and
// vertical gap minus the reset gap open.
// Input stalls only while a final cell waits behind an untaken result.

module local_affine_gap_alignment_scorer_top #(
    parameter int MAX_COLS   = lags_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = lags_pkg::DEF_MAX_ROWS,
    parameter int SCORE_BITS = lags_pkg::DEF_SCORE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lags_pkg::CELL_W-1:0]  i_cell_score,
    input  logic                                i_last_cell,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lags_pkg::OUT_SCORE_W-1:0]    o_best_score,
    output logic [lags_pkg::OUT_POS_W-1:0]      o_end_row,
    output logic [lags_pkg::OUT_POS_W-1:0]      o_end_col,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lags_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lags_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Row buffer entry after reset: best 0, vertical gap minus the reset gap open
    localparam logic [2*SCORE_BITS-1:0] BUF_INIT =
        {{SCORE_BITS{1'b0}}, SCORE_BITS'(0 - int'(lags_pkg::RST_GAP_OPEN))};

    lags_pkg::t_cfg                     cfg;
    lags_pkg::t_cell_ctl                ctl;
    logic                               out_stall;
    logic                               rd_en;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic                               wr_en;
    logic [2*SCORE_BITS-1:0]            wr_data;
    logic [2*SCORE_BITS-1:0]            rd_data;
    logic [ROW_W-1:0]                   s1_row;
    logic [COL_W-1:0]                   s1_col;
    logic signed [lags_pkg::CELL_W-1:0] s1_score;

    assign out_stall = o_out_valid && !i_out_ready;

    lags_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lags_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .COL_W    (COL_W),
        .ROW_W    (ROW_W),
        .ADDR_W   (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cell_score (i_cell_score),
        .i_last_cell  (i_last_cell),
        .i_row_length (cfg.row_length),
        .i_out_stall  (out_stall),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_ctl        (ctl),
        .o_addr       (wr_addr),
        .o_row        (s1_row),
        .o_col        (s1_col),
        .o_score      (s1_score)
    );

    lags_rowbuf #(
        .DEPTH     (MAX_COLS),
        .ADDR_W    (ADDR_W),
        .DATA_W    (2*SCORE_BITS),
        .INIT_DATA (BUF_INIT)
    ) u_rowbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lags_cell #(
        .SCORE_BITS (SCORE_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_cell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_row        (s1_row),
        .i_col        (s1_col),
        .i_score      (s1_score),
        .i_rd_data    (rd_data),
        .i_cfg        (cfg),
        .o_wr_en      (wr_en),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_best_score (o_best_score),
        .o_end_row    (o_end_row),
        .o_end_col    (o_end_col)
    );

endmodule

// ===== src/lags_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lags_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [lags_pkg::OUT_SCORE_W-1:0]    o_best_score,
    input  logic [lags_pkg::OUT_POS_W-1:0]      o_end_row,
    input  logic [lags_pkg::OUT_POS_W-1:0]      o_end_col
);

    // A result beat waiting for the sink keeps its contents
    `LAGS_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_best_score) && $stable(o_end_row) && $stable(o_end_col), "result beat changed while stalled")

    // Every matrix has a best cell, so a result always names a position
    `LAGS_ASSERT_IMP(a_pos_set, o_out_valid, o_end_row != '0 && o_end_col != '0, "result without end position")

    // Input is held off only by an untaken result
    `LAGS_ASSERT_IMP(a_in_stall, !o_in_ready, o_out_valid && !i_out_ready, "input stalled with result slot free")

endmodule

bind local_affine_gap_alignment_scorer_top lags_checker u_lags_checker (.*);

// ===== verif/local_affine_gap_alignment_scorer_top_tb.sv =====
`timescale 1ns / 1ps

module local_affine_gap_alignment_scorer_top_tb;
    import lags_pkg::*;

    localparam int     MAX_COLS      = DEF_MAX_COLS;
    localparam int     MAX_ROWS      = DEF_MAX_ROWS;
    localparam int     SCORE_W       = DEF_SCORE_BITS;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint TIMEOUT_NS    = 24_000_000;

    typedef logic signed [SCORE_W-1:0] score_t;

    typedef struct {
        logic [OUT_SCORE_W-1:0] score;
        logic [OUT_POS_W-1:0]   row;
        logic [OUT_POS_W-1:0]   col;
    } align_result_t;

    // Tracks the alignment matrix as the block should, and holds the
    // best-score reports still owed by the block.
    class align_score_tracker;
        logic [LEN_W-1:0] row_len;
        logic [GAP_W-1:0] gap_open;
        logic [GAP_W-1:0] gap_ext;
        score_t           best_row[MAX_COLS];
        score_t           vgap_row[MAX_COLS];
        score_t           diag_score;
        score_t           left_score;
        score_t           hgap_score;
        longint           max_score;
        int               row_no;
        int               col_no;
        int               max_row;
        int               max_col;
        align_result_t    expected_results[$];
        int               errors;

        function new();
            row_len    = RST_ROW_LENGTH;
            gap_open   = RST_GAP_OPEN;
            gap_ext    = RST_GAP_EXTEND;
            for (int i = 0; i < MAX_COLS; i++) begin
                best_row[i] = '0;
                vgap_row[i] = -score_t'(RST_GAP_OPEN);
            end
            diag_score = '0;
            left_score = '0;
            hgap_score = -score_t'(RST_GAP_OPEN);
            errors     = 0;
            restart();
        endfunction

        function void restart();
            row_no    = 1;
            col_no    = 1;
            max_score = -1;
            max_row   = 0;
            max_col   = 0;
        endfunction

        // Saturate to the score width
        function longint clip(longint x);
            longint hi;
            hi = (longint'(1) <<< (SCORE_W - 1)) - 1;
            if (x > hi) return hi;
            if (x < -hi - 1) return -hi - 1;
            return x;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROW_LENGTH: row_len = val[LEN_W-1:0];
                REG_GAP_OPEN:   gap_open = val[GAP_W-1:0];
                REG_GAP_EXTEND: gap_ext = val[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // One accepted cell beat
        function void take_cell(logic signed [CELL_W-1:0] cs, logic last);
            int            len;
            int            k;
            longint        g, h, m, up_c, up_d, dg, lf, hg, ev, dv, cv, t;
            bit            first_row, first_col;
            align_result_t r;

            len = row_len;
            if (len == 0) len = 1;
            else if (len > MAX_COLS) len = MAX_COLS;
            // column counter beyond a shortened row opens a new row
            if (col_no > len || col_no == 0) begin
                col_no = 1;
                if (row_no < MAX_ROWS) row_no++;
            end

            g = gap_open;
            h = gap_ext;
            m = g + h;
            k = (col_no - 1) % MAX_COLS;
            first_row = (row_no <= 1);
            first_col = (col_no == 1);

            up_c = first_row ? 0 : best_row[k];
            up_d = first_row ? -g : vgap_row[k];
            dg   = first_col ? 0 : diag_score;
            lf   = first_col ? 0 : left_score;
            hg   = first_col ? -g : hgap_score;

            // horizontal gap: open or extend
            ev = clip(lf - m);
            t  = clip(hg - h);
            if (!(ev > t)) ev = t;
            // vertical gap: open or extend
            dv = clip(up_c - m);
            t  = clip(up_d - h);
            if (!(dv > t)) dv = t;

            cv = clip(dg + cs);
            if (ev > cv) cv = ev;
            if (dv > cv) cv = dv;

            diag_score = score_t'(up_c);
            if (cv < 0) begin
                best_row[k] = '0;
                vgap_row[k] = score_t'(-g);
                left_score  = '0;
                hgap_score  = score_t'(-g);
                cv          = 0;
            end else begin
                best_row[k] = score_t'(cv);
                vgap_row[k] = score_t'(dv);
                left_score  = score_t'(cv);
                hgap_score  = score_t'(ev);
            end

            if (cv > max_score) begin
                max_score = cv;
                max_row   = row_no;
                max_col   = col_no;
            end

            if (last) begin
                t = max_score;
                if (t < 0) t = 0;
                if (t > longint'(OUT_SCORE_MAX)) t = longint'(OUT_SCORE_MAX);
                r.score = t[OUT_SCORE_W-1:0];
                r.row   = max_row[OUT_POS_W-1:0];
                r.col   = max_col[OUT_POS_W-1:0];
                expected_results.push_back(r);
                restart();
                return;
            end

            if (col_no >= len) begin
                col_no = 1;
                if (row_no < MAX_ROWS) row_no++;
            end else begin
                col_no++;
            end
        endfunction

        // One accepted result beat
        function void check_result(logic [OUT_SCORE_W-1:0] score,
                                   logic [OUT_POS_W-1:0] row, logic [OUT_POS_W-1:0] col);
            align_result_t e;
            if (expected_results.size() == 0) begin
                $error("unexpected result: score %0d row %0d col %0d", score, row, col);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (score !== e.score) begin
                $error("best_score: expected %0d, actual %0d", e.score, score);
                errors++;
            end
            if (row !== e.row) begin
                $error("end_row: expected %0d, actual %0d", e.row, row);
                errors++;
            end
            if (col !== e.col) begin
                $error("end_col: expected %0d, actual %0d", e.col, col);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic signed [CELL_W-1:0]       i_cell_score;
    logic                           i_last_cell;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [OUT_SCORE_W-1:0]         o_best_score;
    logic [OUT_POS_W-1:0]           o_end_row;
    logic [OUT_POS_W-1:0]           o_end_col;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index;
    logic [CFG_DATA_W-1:0]          i_cfg_data;

    align_score_tracker tracker;
    int                 in_idle_pct;
    int                 out_stall_pct;
    logic               out_hold = 1'b0;

    local_affine_gap_alignment_scorer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cell_score (i_cell_score),
        .i_last_cell  (i_last_cell),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_best_score (o_best_score),
        .o_end_row    (o_end_row),
        .o_end_col    (o_end_col),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check each beat taken, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            tracker.check_result(o_best_score, o_end_row, o_end_col);
        if (out_hold)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Random substitution score: mostly small matches and mismatches, some extremes and raw values
    function automatic logic signed [CELL_W-1:0] rand_cell();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35) return CELL_W'($urandom_range(240, 16));
        if (sel < 65) return CELL_W'(0 - int'($urandom_range(240, 1)));
        if (sel < 75) return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        return CELL_W'($urandom());
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return CFG_DATA_W'($urandom_range(4, 1));
        if (sel < 70) return CFG_DATA_W'($urandom_range(8, 5));
        if (sel < 80) return CFG_DATA_W'(1);
        if (sel < 90) return CFG_DATA_W'($urandom());
        return CFG_DATA_W'(MAX_COLS);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) return '0;
        if (sel < 35) return '1;
        if (sel < 70) return CFG_DATA_W'($urandom_range(255));
        return CFG_DATA_W'($urandom());
    endfunction

    // Offer one cell beat, with random idle cycles ahead of it
    task automatic send_cell(logic signed [CELL_W-1:0] cs, logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cell_score <= cs;
        i_last_cell  <= last;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        tracker.take_cell(cs, last);
    endtask

    task automatic in_stop();
        i_in_valid <= 1'b0;
    endtask

    // Valid is left high; the caller drops it after the last write
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        tracker.set_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] gopen,
                             logic [CFG_DATA_W-1:0] gext);
        write_reg(REG_ROW_LENGTH, len);
        write_reg(REG_GAP_OPEN, gopen);
        write_reg(REG_GAP_EXTEND, gext);
        i_cfg_valid <= 1'b0;
    endtask

    // All owed results in, then let the pipeline empty
    task automatic wait_drain();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic hold_output(int cycles);
        out_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        out_hold <= 1'b0;
    endtask

    // Well-formed matrices with random content, now and then cut short
    task automatic random_phase(int idle_in, int stall_out);
        int                    cells, n_cells, n_mats, len_eff;
        logic [CFG_DATA_W-1:0] len_reg;
        in_idle_pct   = idle_in;
        out_stall_pct = stall_out;
        for (int sub = 0; sub < 3; sub++) begin
            wait_drain();
            len_reg = pick_len();
            configure(len_reg, pick_gap(), pick_gap());
            len_eff = len_reg[LEN_W-1:0];
            if (len_eff == 0) len_eff = 1;
            else if (len_eff > MAX_COLS) len_eff = MAX_COLS;
            n_cells = 0;
            n_mats  = 0;
            while (n_cells < 35 || n_mats < 5) begin
                if (len_eff <= 8)
                    cells = len_eff * $urandom_range(4, 1);
                else
                    cells = $urandom_range(12, 1);
                if ($urandom_range(4) == 0) cells = $urandom_range(cells, 1);
                repeat (cells - 1) send_cell(rand_cell(), 1'b0);
                send_cell(rand_cell(), 1'b1);
                n_cells += cells;
                n_mats++;
            end
            in_stop();
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cell_score <= '0;
        i_last_cell  <= 1'b0;
        i_out_ready  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_ROW_LENGTH;
        i_cfg_data   <= '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Row widened part way through: later columns read buffer entries untouched since reset
        configure(12'd1, 12'd160, 12'd16);
        send_cell(16'sd40, 1'b0);
        send_cell(16'sd50, 1'b0);
        in_stop();
        wait_drain();
        configure(12'd3, 12'd160, 12'd16);
        send_cell(16'sd60, 1'b0);
        send_cell(16'sd70, 1'b0);
        send_cell(16'sd80, 1'b1);
        in_stop();
        wait_drain();
        configure(CFG_DATA_W'(RST_ROW_LENGTH), CFG_DATA_W'(RST_GAP_OPEN),
                  CFG_DATA_W'(RST_GAP_EXTEND));

        // Reset settings: single-cell matrices at both score extremes
        send_cell(16'sh7fff, 1'b1);
        send_cell(16'sh8000, 1'b1);
        in_stop();
        wait_drain();

        // Top-bit-set length data masks to 2; largest penalties
        configure(12'h802, '1, '1);
        send_cell(16'sd100, 1'b0);
        send_cell(-16'sd5, 1'b0);
        send_cell(-16'sd5, 1'b0);
        send_cell(16'sd200, 1'b1);
        in_stop();
        wait_drain();

        // Free gaps carry scores across bad cells
        configure(12'd3, '0, '0);
        send_cell(16'sd50, 1'b0);
        send_cell(16'sh8000, 1'b0);
        send_cell(16'sh8000, 1'b0);
        send_cell(16'sd10, 1'b0);
        send_cell(16'sd10, 1'b0);
        send_cell(16'sd10, 1'b1);
        in_stop();
        wait_drain();

        // Length zero behaves as one column
        configure(12'h800, 12'd160, 12'd16);
        send_cell(16'sd30, 1'b0);
        send_cell(16'sd40, 1'b0);
        send_cell(16'sd40, 1'b1);
        in_stop();
        wait_drain();

        // Length above the buffer size clamps to it
        configure('1, 12'd32, 12'd8);
        send_cell(16'sd5, 1'b0);
        send_cell(16'sd7, 1'b1);
        in_stop();
        wait_drain();

        // Row shortened part way through: next cell opens a new row
        configure(12'd4, 12'd160, 12'd16);
        send_cell(16'sd20, 1'b0);
        send_cell(16'sd30, 1'b0);
        send_cell(16'sd40, 1'b0);
        in_stop();
        wait_drain();
        configure(12'd2, 12'd160, 12'd16);
        send_cell(16'sd60, 1'b0);
        send_cell(16'sd60, 1'b1);
        in_stop();

        // Random matrices under each idling mix
        random_phase(0, 0);
        random_phase(85, 0);
        random_phase(0, 85);
        random_phase(33, 33);

        // Receiver held off while one-cell matrices keep coming
        in_idle_pct   = 0;
        out_stall_pct = 0;
        wait_drain();
        configure(12'd1, 12'd160, 12'd16);
        fork
            hold_output(400);
            begin
                repeat (60) send_cell(rand_cell(), 1'b1);
                in_stop();
            end
        join

        wait_drain();
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/lags_pkg.sv
src/lags_cfg.sv
src/lags_seq.sv
src/lags_rowbuf.sv
src/lags_cell.sv
src/local_affine_gap_alignment_scorer_top.sv
src/lags_checker.sv
verif/local_affine_gap_alignment_scorer_top_tb.sv
